>>> design/tt_pkg.sv
// ----------------------------------------------------------------------------
// tt_pkg: shared types and constants for the transposition table
// Table geometry, item and entry layouts, front/back control bundles and
// the sequencer state type.
// ----------------------------------------------------------------------------
package tt_pkg;

	// table geometry: direct-mapped, indexed by the low bits of hash_low
	localparam int INDEX_BITS = 12;
	localparam int ENTRIES    = 1 << INDEX_BITS;

	// queue between front and back (power of two)
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	// action codes
	localparam logic ACT_PROBE = 1'b0;
	localparam logic ACT_STORE = 1'b1;

	// one accepted input beat
	typedef struct packed {
		logic               action;
		logic [63:0]        hash_high;
		logic [63:0]        hash_low;
		logic               side;
		logic signed [15:0] score;
		logic [7:0]         search_depth;
		logic               is_exact;
	} item_t;

	// one table slot
	typedef struct packed {
		logic               valid;
		logic [63:0]        tag_high;
		logic [63:0]        tag_low;
		logic               side;
		logic signed [15:0] score;
		logic [7:0]         depth;
		logic               exact;
	} entry_t;

	// front -> back: head of the queue
	typedef struct packed {
		logic  valid;
		item_t item;
	} fe_stat_t;

	// back -> front: dequeue and clear-pass status
	typedef struct packed {
		logic pop;
		logic clearing;
	} bk_ctl_t;

	// back-end sequencer
	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_FETCH,
		BK_EVAL
	} bk_state_t;

endpackage

>>> design/tt_front.sv
// ----------------------------------------------------------------------------
// tt_front: input port and command queue
// Accepts item beats, packs them and holds them in a short queue until the
// back end takes them.
// ----------------------------------------------------------------------------
module tt_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  logic                 action,
	input  logic [63:0]          hash_high,
	input  logic [63:0]          hash_low,
	input  logic                 side,
	input  logic signed [15:0]   score,
	input  logic [7:0]           search_depth,
	input  logic                 is_exact,
	input  tt_pkg::bk_ctl_t      ctl,
	output tt_pkg::fe_stat_t     fe
);

	tt_pkg::item_t                    queue_q [tt_pkg::QUEUE_DEPTH];
	logic [tt_pkg::QPTR_BITS-1:0]     wr_ptr_q;
	logic [tt_pkg::QPTR_BITS-1:0]     rd_ptr_q;
	logic [tt_pkg::QCNT_BITS-1:0]     count_q;
	tt_pkg::item_t                    item_in;
	logic                             push;

	// pack the incoming beat
	always_comb begin
		item_in.action       = action;
		item_in.hash_high    = hash_high;
		item_in.hash_low     = hash_low;
		item_in.side         = side;
		item_in.score        = score;
		item_in.search_depth = search_depth;
		item_in.is_exact     = is_exact;
	end

	// no beats while the table is being cleared or the queue is full
	assign item_stall = ctl.clearing ||
		(count_q == tt_pkg::QCNT_BITS'(tt_pkg::QUEUE_DEPTH));
	assign push = item_valid && !item_stall;

	assign fe.valid = (count_q != '0);
	assign fe.item  = queue_q[rd_ptr_q];

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= item_in;
		end
	end

	// queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (ctl.pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, ctl.pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> design/tt_back.sv
// ----------------------------------------------------------------------------
// tt_back: table memory and probe/store execution
// Clears the table after reset, then reads the slot for each queued item,
// applies the hit or replacement rule, writes back accepted stores and registers the result.
// ----------------------------------------------------------------------------
module tt_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tt_pkg::fe_stat_t     fe,
	output tt_pkg::bk_ctl_t      ctl,
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic                 hit,
	output logic                 accepted,
	output logic signed [15:0]   found_score,
	output logic [7:0]           found_depth,
	output logic                 found_exact
);

	tt_pkg::entry_t                    mem [tt_pkg::ENTRIES];
	tt_pkg::entry_t                    rd_data_q;
	tt_pkg::entry_t                    wr_data;
	tt_pkg::item_t                     item_q;
	tt_pkg::bk_state_t                 state_q;
	tt_pkg::bk_state_t                 state_d;
	logic [tt_pkg::INDEX_BITS-1:0]     clr_idx_q;
	logic [tt_pkg::INDEX_BITS-1:0]     wr_addr;
	logic                              out_valid_q;
	logic                              out_free;
	logic                              eval_go;
	logic                              is_store;
	logic                              match;
	logic                              refuse;
	logic                              wr_en;
	logic                              hit_d;
	logic                              accepted_d;

	assign out_free = !out_valid_q || !result_stall;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			tt_pkg::BK_CLEAR: begin
				if (clr_idx_q == '1) begin
					state_d = tt_pkg::BK_FETCH;
				end
			end
			tt_pkg::BK_FETCH: begin
				if (fe.valid) begin
					state_d = tt_pkg::BK_EVAL;
				end
			end
			tt_pkg::BK_EVAL: begin
				if (out_free) begin
					state_d = tt_pkg::BK_FETCH;
				end
			end
			default: state_d = tt_pkg::BK_CLEAR;
		endcase
	end

	// state outputs
	always_comb begin
		ctl.pop      = 1'b0;
		ctl.clearing = 1'b0;
		eval_go      = 1'b0;
		case (state_q)
			tt_pkg::BK_CLEAR: ctl.clearing = 1'b1;
			tt_pkg::BK_FETCH: ctl.pop      = fe.valid;
			tt_pkg::BK_EVAL:  eval_go      = out_free;
			default:          ctl.clearing = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= tt_pkg::BK_CLEAR;
			clr_idx_q <= '0;
		end else begin
			state_q <= state_d;
			if (ctl.clearing) begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
		end
	end

	// hold the item under evaluation
	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			item_q <= fe.item;
		end
	end

	// compare against the slot read back
	assign is_store = (item_q.action == tt_pkg::ACT_STORE);
	assign match    = rd_data_q.valid &&
		(rd_data_q.tag_high == item_q.hash_high) &&
		(rd_data_q.tag_low == item_q.hash_low) &&
		(rd_data_q.side == item_q.side);
	assign refuse   = match && ((rd_data_q.depth > item_q.search_depth) ||
		((rd_data_q.depth == item_q.search_depth) && rd_data_q.exact));
	assign hit_d      = !is_store && match;
	assign accepted_d = is_store && !refuse;

	// write port: clear pass or accepted store
	assign wr_en   = ctl.clearing || (eval_go && accepted_d);
	assign wr_addr = ctl.clearing ? clr_idx_q : item_q.hash_low[tt_pkg::INDEX_BITS-1:0];
	always_comb begin
		wr_data = '0;
		if (!ctl.clearing) begin
			wr_data.valid    = 1'b1;
			wr_data.tag_high = item_q.hash_high;
			wr_data.tag_low  = item_q.hash_low;
			wr_data.side     = item_q.side;
			wr_data.score    = item_q.score;
			wr_data.depth    = item_q.search_depth;
			wr_data.exact    = item_q.is_exact;
		end
	end

	// table memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (ctl.pop) begin
			rd_data_q <= mem[fe.item.hash_low[tt_pkg::INDEX_BITS-1:0]];
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (eval_go) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (eval_go) begin
			hit         <= hit_d;
			accepted    <= accepted_d;
			found_score <= hit_d ? rd_data_q.score : '0;
			found_depth <= hit_d ? rd_data_q.depth : '0;
			found_exact <= hit_d && rd_data_q.exact;
		end
	end

	assign result_valid = out_valid_q;

	// a new result only comes out of the evaluate step
	a_result_from_eval: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == tt_pkg::BK_EVAL))
		else $error("result raised without an evaluate step");

	// nothing leaves the queue during the clear pass
	a_no_pop_clear: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.clearing |-> !ctl.pop)
		else $error("queue popped during clear pass");

	// entering evaluate always follows a dequeue
	a_eval_after_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == tt_pkg::BK_EVAL && $past(state_q) == tt_pkg::BK_FETCH)
		|-> $past(ctl.pop))
		else $error("evaluate without a dequeued item");

	// probe and store outcomes are exclusive
	a_hit_xor_store: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(hit && accepted))
		else $error("hit and accepted both set");

endmodule

>>> design/transposition_table.sv
// ----------------------------------------------------------------------------
// transposition_table: direct-mapped game-tree transposition table
// Probe and store of 128-bit-keyed entries with a depth-based replacement
// rule; one result beat per item beat.
// ----------------------------------------------------------------------------
// Usage:
//   Item channel (item_valid / item_stall) carries a probe or a store with
//   the hash halves, side to move and, for stores, score, depth and exact.
//   Result channel (result_valid / result_stall) returns one beat per item:
//   hit and the found fields for a probe, accepted for a store.
//   An item is popped in the fetch state as its slot is read, then checked
//   in the evaluate state, whose result register waits on a free output.
//   Items pass one at a time over the single table memory, read then write.
//   Reset: arst_n clears control state, then the back end walks the table
//   clearing every slot's valid bit, one slot per cycle (ENTRIES slots,
//   4096 by default); item_stall stays high for that whole pass.
//   A stalled result holds in the output register; the two-deep item queue
//   keeps taking beats until it fills, then item_stall rises.
// ----------------------------------------------------------------------------
module transposition_table (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  logic                 action,
	input  logic [63:0]          hash_high,
	input  logic [63:0]          hash_low,
	input  logic                 side,
	input  logic signed [15:0]   score,
	input  logic [7:0]           search_depth,
	input  logic                 is_exact,
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic                 hit,
	output logic                 accepted,
	output logic signed [15:0]   found_score,
	output logic [7:0]           found_depth,
	output logic                 found_exact
);

	tt_pkg::fe_stat_t fe;
	tt_pkg::bk_ctl_t  ctl;

	tt_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.action       (action),
		.hash_high    (hash_high),
		.hash_low     (hash_low),
		.side         (side),
		.score        (score),
		.search_depth (search_depth),
		.is_exact     (is_exact),
		.ctl          (ctl),
		.fe           (fe)
	);

	tt_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.fe           (fe),
		.ctl          (ctl),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.hit          (hit),
		.accepted     (accepted),
		.found_score  (found_score),
		.found_depth  (found_depth),
		.found_exact  (found_exact)
	);

endmodule
